### hdl/gsbs_pkg.sv
// Package for the grid store bilinear sampler: operation codes, register
// indexes, sequencer states and the control bundle passed to the datapath.
// Depends on nothing; every other file of the block but gsbs_ram imports it.
package gsbs_pkg;

	// Field widths of the transaction payloads.
	localparam int OP_W    = 2;
	localparam int COORD_W = 8;
	localparam int VAL_W   = 32;
	localparam int POS_W   = 24;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int GW_W    = 9;
	localparam int SCALE_W = 24;

	localparam logic REG_GRID_WIDTH    = 1'b0;
	localparam logic REG_SCALE_INVERSE = 1'b1;

	localparam logic [GW_W-1:0]    GRID_WIDTH_RST = 9'd256;
	localparam logic [SCALE_W-1:0] SCALE_INV_RST  = 24'h010000;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = 48;
	localparam int WT_W    = 16;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_SAMPLE = 2'd2
	} op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_READ_DATA,
		ST_MUL_X,
		ST_MUL_Y,
		ST_AXIS_X,
		ST_AXIS_Y,
		ST_FETCH,
		ST_ROW1,
		ST_ROW2,
		ST_ROW1_DONE,
		ST_ROW2_DONE,
		ST_COL,
		ST_COL_WAIT,
		ST_COL_DONE,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MS_POS_X,
		MS_POS_Y,
		MS_ROW1,
		MS_ROW2,
		MS_COL
	} mul_sel_t;

	typedef enum logic [1:0] {
		AS_ITEM,
		AS_FETCH,
		AS_CLEAR
	} addr_sel_t;

	typedef struct packed {
		logic      load;
		logic      clr_we;
		logic      mem_we;
		logic      rd_en;
		addr_sel_t addr_sel;
		logic [1:0] rd_idx;
		logic      cap_v;
		logic [1:0] cap_idx;
		logic      cap_read;
		logic      mul_go;
		mul_sel_t  mul_sel;
		logic      cap_ax_x;
		logic      cap_ax_y;
		logic      cap_r1;
		logic      cap_r2;
		logic      cap_col;
		logic      out_load;
	} ctrl_t;

endpackage

### hdl/gsbs_in_if.sv
// Request channel of the grid store bilinear sampler: valid, ready and the
// operation payload. Depends on gsbs_pkg for the field widths.
interface gsbs_in_if;
	import gsbs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic [COORD_W-1:0]        grid_x;
	logic [COORD_W-1:0]        grid_y;
	logic signed [VAL_W-1:0]   write_value;
	logic signed [POS_W-1:0]   pos_x;
	logic signed [POS_W-1:0]   pos_y;

	modport source (
		output valid, operation, grid_x, grid_y, write_value, pos_x, pos_y,
		input  ready
	);

	modport sink (
		input  valid, operation, grid_x, grid_y, write_value, pos_x, pos_y,
		output ready
	);

endinterface

### hdl/gsbs_out_if.sv
// Result channel of the grid store bilinear sampler: valid, ready and the
// result value. Depends on gsbs_pkg for the field width.
interface gsbs_out_if;
	import gsbs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] result_value;

	modport source (
		output valid, result_value,
		input  ready
	);

	modport sink (
		input  valid, result_value,
		output ready
	);

endinterface

### hdl/grid_store_bilinear_sampler_unit.sv
// Grid store with bilinear sampling: a MAX_EDGE x MAX_EDGE store of signed
// Q16.16 values, each request written, read or sampled through one RAM port.
// Usage:
//   Requests arrive on req (valid/ready); a transaction is taken when both
//   are high. Operation write stores a cell inside the active width, read
//   returns a cell or zero, sample returns the bilinear interpolation at a
//   scaled world position. Writes and unknown operations give no result.
//   Results leave on rsp (valid/ready) from an output register, so a finished
//   result may wait while the next request is taken.
//   The time a request takes is set by the single RAM port (four cell reads
//   for a sample) and the shared two-stage multiplier (five products); a
//   finished result also waits while the output register is still full.
//   After reset the clearing pass writes zero to every cell; req.ready stays
//   low meanwhile. Configuration writes are taken at any time and must only
//   be issued while idle.
//   A stalled rsp holds its result; the block then waits before its next one.
// Depends on gsbs_pkg, gsbs_in_if, gsbs_out_if, gsbs_ram, gsbs_mul, gsbs_seq.
module grid_store_bilinear_sampler_unit #(
	parameter int MAX_EDGE = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gsbs_in_if.sink                          req,
	gsbs_out_if.source                       rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gsbs_pkg::PADDR_W-1:0]     paddr,
	input  logic [gsbs_pkg::PDATA_W-1:0]     pwdata,
	output logic [gsbs_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	import gsbs_pkg::*;

	localparam int IW    = $clog2(MAX_EDGE);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int WW    = (IW + 1 > GW_W) ? IW + 1 : GW_W;
	localparam logic [WW-1:0] EDGE_W = WW'(MAX_EDGE);

	ctrl_t ctrl;
	logic  clr_unused_ready;

	// Configuration registers.
	logic [GW_W-1:0]    grid_width_q;
	logic [SCALE_W-1:0] scale_q;

	// Request held for the whole operation.
	logic [OP_W-1:0]          op_q;
	logic [COORD_W-1:0]       gx_q;
	logic [COORD_W-1:0]       gy_q;
	logic signed [VAL_W-1:0]  write_value_q;
	logic signed [POS_W-1:0]  pos_x_q;
	logic signed [POS_W-1:0]  pos_y_q;

	// Sample datapath.
	logic [IW-1:0]            x1_q, x2_q, y1_q, y2_q;
	logic [WT_W-1:0]          wx_q, wy_q;
	logic signed [VAL_W-1:0]  v_q [4];
	logic signed [VAL_W-1:0]  r1_q, r2_q;
	logic signed [VAL_W-1:0]  res_q;

	// Output register.
	logic                     out_valid_q;
	logic signed [VAL_W-1:0]  out_data_q;
	logic                     out_free;

	// Memory port.
	logic [AW-1:0]            clr_addr;
	logic [AW-1:0]            ram_addr;
	logic                     ram_we;
	logic [VAL_W-1:0]         ram_wdata;
	logic [VAL_W-1:0]         ram_rdata;

	// Multiplier port.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [POS_W-1:0]   cell_idx;
	logic signed [VAL_W-1:0]   prod_hi;

	logic [WW-1:0] gw_ext;
	logic [WW-1:0] eff_w;
	logic          zero_w;
	logic          item_in_range;
	logic          cfg_wr;

	// Clamp a cell index to 0 .. w-1 (to 0 when w is zero).
	function automatic logic [IW-1:0] clamp_cell(input logic signed [POS_W:0] c,
			input logic [WW-1:0] w);
		logic signed [POS_W+1:0] ce;
		logic signed [POS_W+1:0] we;
		ce = (POS_W + 2)'(c);
		we = $signed({{(POS_W + 2 - WW){1'b0}}, w});
		if (ce >= we) begin
			ce = we - (POS_W + 2)'(1);
		end
		if (ce < 0) begin
			ce = '0;
		end
		return ce[IW-1:0];
	endfunction

	// APB register file; writes complete in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_WIDTH_RST;
			scale_q      <= SCALE_INV_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_GRID_WIDTH:    grid_width_q <= pwdata[GW_W-1:0];
				REG_SCALE_INVERSE: scale_q      <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GRID_WIDTH:    prdata = PDATA_W'(grid_width_q);
			REG_SCALE_INVERSE: prdata = PDATA_W'(scale_q);
			default:           prdata = '0;
		endcase
	end

	// Active width, limited to the store's edge.
	assign gw_ext        = WW'(grid_width_q);
	assign eff_w         = (gw_ext > EDGE_W) ? EDGE_W : gw_ext;
	assign zero_w        = (eff_w == '0);
	assign item_in_range = (WW'(gx_q) < eff_w) && (WW'(gy_q) < eff_w);

	// Sequencer.
	gsbs_seq #(
		.AW (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.operation),
		.out_free (out_free),
		.in_ready (clr_unused_ready),
		.ctrl     (ctrl),
		.clr_addr (clr_addr)
	);

	assign req.ready = clr_unused_ready;

	// Capture the request.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			op_q          <= req.operation;
			gx_q          <= req.grid_x;
			gy_q          <= req.grid_y;
			write_value_q <= req.write_value;
			pos_x_q       <= req.pos_x;
			pos_y_q       <= req.pos_y;
		end
	end

	// Memory address: clearing sweep, request cell or one of the four neighbors.
	always_comb begin
		unique case (ctrl.addr_sel)
			AS_CLEAR: ram_addr = clr_addr;
			AS_FETCH: ram_addr = {ctrl.rd_idx[1] ? y2_q : y1_q,
				ctrl.rd_idx[0] ? x2_q : x1_q};
			AS_ITEM:  ram_addr = {IW'(gy_q), IW'(gx_q)};
			default:  ram_addr = {IW'(gy_q), IW'(gx_q)};
		endcase
	end

	assign ram_we    = ctrl.clr_we | (ctrl.mem_we & item_in_range & (op_q == OP_WRITE));
	assign ram_wdata = ctrl.clr_we ? '0 : write_value_q;

	gsbs_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Multiplier operands: position times scale, or weight times difference.
	always_comb begin
		unique case (ctrl.mul_sel)
			MS_POS_X: begin
				mul_a = MUL_A_W'(pos_x_q);
				mul_b = $signed({1'b0, scale_q});
			end
			MS_POS_Y: begin
				mul_a = MUL_A_W'(pos_y_q);
				mul_b = $signed({1'b0, scale_q});
			end
			MS_ROW1: begin
				mul_a = MUL_A_W'(v_q[0]) - MUL_A_W'(v_q[1]);
				mul_b = $signed({{(MUL_B_W - WT_W){1'b0}}, wx_q});
			end
			MS_ROW2: begin
				mul_a = MUL_A_W'(v_q[2]) - MUL_A_W'(v_q[3]);
				mul_b = $signed({{(MUL_B_W - WT_W){1'b0}}, wx_q});
			end
			MS_COL: begin
				mul_a = MUL_A_W'(r1_q) - MUL_A_W'(r2_q);
				mul_b = $signed({{(MUL_B_W - WT_W){1'b0}}, wy_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	gsbs_mul u_mul (
		.clk  (clk),
		.go   (ctrl.mul_go),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Scaled position: integer part is the cell, the fraction gives the weight.
	assign cell_idx = prod[PROD_W-1:PROD_W-POS_W];
	// Floor of the weighted difference over 2^16, truncated to 32 bits.
	assign prod_hi  = prod[VAL_W+WT_W-1:WT_W];

	always_ff @(posedge clk) begin
		if (ctrl.cap_ax_x) begin
			x1_q <= clamp_cell((POS_W + 1)'(cell_idx), eff_w);
			x2_q <= clamp_cell((POS_W + 1)'(cell_idx) + (POS_W + 1)'(1), eff_w);
			wx_q <= prod[POS_W-1:POS_W-WT_W];
		end
		if (ctrl.cap_ax_y) begin
			y1_q <= clamp_cell((POS_W + 1)'(cell_idx), eff_w);
			y2_q <= clamp_cell((POS_W + 1)'(cell_idx) + (POS_W + 1)'(1), eff_w);
			wy_q <= prod[POS_W-1:POS_W-WT_W];
		end
		// Neighbor cells read as zero when no cell is active.
		if (ctrl.cap_v) begin
			v_q[ctrl.cap_idx] <= zero_w ? '0 : $signed(ram_rdata);
		end
		if (ctrl.cap_r1) begin
			r1_q <= v_q[0] - prod_hi;
		end
		if (ctrl.cap_r2) begin
			r2_q <= v_q[2] - prod_hi;
		end
		if (ctrl.cap_read) begin
			res_q <= item_in_range ? $signed(ram_rdata) : '0;
		end else if (ctrl.cap_col) begin
			res_q <= r1_q - prod_hi;
		end
	end

	// Output register between the sequencer and the result channel.
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_data_q <= res_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_data_q;

	// Fetched data is captured only in the cycle after its read went out.
	a_fetch_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cap_v |-> $past(ctrl.rd_en))
		else $error("neighbor captured without a preceding read");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!out_valid_q || rsp.ready))
		else $error("result register loaded while still full");

	// Row results are taken exactly when their product leaves the multiplier; checked for the first row.
	a_row_timing: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cap_r1 |-> $past(ctrl.mul_go, 2))
		else $error("row result captured before its product was ready");

endmodule

### hdl/gsbs_ram.sv
// Generic single-port RAM with one write or read per cycle and registered
// read data. Depends on nothing.
module gsbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read of the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### hdl/gsbs_mul.sv
// Shared signed multiplier of the sampler: registered operands, then a
// registered product. Depends on gsbs_pkg.
module gsbs_mul (
	input  logic                                 clk,
	input  logic                                 go,
	input  logic signed [gsbs_pkg::MUL_A_W-1:0]  a,
	input  logic signed [gsbs_pkg::MUL_B_W-1:0]  b,
	output logic signed [gsbs_pkg::PROD_W-1:0]   prod
);
	import gsbs_pkg::*;

	logic signed [MUL_A_W-1:0] a_s1;
	logic signed [MUL_B_W-1:0] b_s1;
	logic signed [PROD_W-1:0]  prod_s2;

	// Operand stage, loaded when the sequencer starts a multiplication.
	always_ff @(posedge clk) begin
		if (go) begin
			a_s1 <= a;
			b_s1 <= b;
		end
	end

	// Product stage; only the low bits are ever significant here.
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(a_s1 * b_s1);
	end

	assign prod = prod_s2;

endmodule

### hdl/gsbs_seq.sv
// Sequencer of the sampler: runs the clearing pass after reset and steps
// each operation through memory accesses and the shared multiplier.
// Depends on gsbs_pkg for the state type and the control bundle.
module gsbs_seq #(
	parameter int AW = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [gsbs_pkg::OP_W-1:0] in_op,
	input  logic                    out_free,
	output logic                    in_ready,
	output gsbs_pkg::ctrl_t         ctrl,
	output logic [AW-1:0]           clr_addr
);
	import gsbs_pkg::*;

	localparam logic [2:0] FETCH_END = 3'd4;

	state_t        state_q, state_d;
	logic [AW-1:0] clr_cnt_q;
	logic [2:0]    fetch_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Clearing pass address and the four-cell fetch counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			fetch_q   <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (state_q == ST_AXIS_Y) begin
				fetch_q <= '0;
			end else if (state_q == ST_FETCH) begin
				fetch_q <= fetch_q + 3'd1;
			end
		end
	end

	assign clr_addr = clr_cnt_q;

	// Next state and control outputs.
	always_comb begin
		state_d       = state_q;
		ctrl          = '0;
		ctrl.mul_sel  = MS_POS_X;
		ctrl.addr_sel = AS_ITEM;
		ctrl.rd_idx   = fetch_q[1:0];
		ctrl.cap_idx  = 2'(fetch_q - 3'd1);
		in_ready      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctrl.clr_we   = 1'b1;
				ctrl.addr_sel = AS_CLEAR;
				if (&clr_cnt_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					unique case (in_op)
						OP_WRITE:  state_d = ST_WRITE;
						OP_READ:   state_d = ST_READ;
						OP_SAMPLE: state_d = ST_MUL_X;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: begin
				ctrl.mem_we = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_READ: begin
				ctrl.rd_en = 1'b1;
				state_d    = ST_READ_DATA;
			end
			ST_READ_DATA: begin
				ctrl.cap_read = 1'b1;
				state_d       = ST_OUT;
			end
			ST_MUL_X: begin
				ctrl.mul_go  = 1'b1;
				ctrl.mul_sel = MS_POS_X;
				state_d      = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				ctrl.mul_go  = 1'b1;
				ctrl.mul_sel = MS_POS_Y;
				state_d      = ST_AXIS_X;
			end
			ST_AXIS_X: begin
				ctrl.cap_ax_x = 1'b1;
				state_d       = ST_AXIS_Y;
			end
			ST_AXIS_Y: begin
				ctrl.cap_ax_y = 1'b1;
				state_d       = ST_FETCH;
			end
			ST_FETCH: begin
				// Reads go out on counts 0 to 3, data is captured on counts 1 to 4.
				ctrl.addr_sel = AS_FETCH;
				ctrl.rd_en    = (fetch_q != FETCH_END);
				ctrl.cap_v    = (fetch_q != 3'd0);
				if (fetch_q == FETCH_END) begin
					state_d = ST_ROW1;
				end
			end
			ST_ROW1: begin
				ctrl.mul_go  = 1'b1;
				ctrl.mul_sel = MS_ROW1;
				state_d      = ST_ROW2;
			end
			ST_ROW2: begin
				ctrl.mul_go  = 1'b1;
				ctrl.mul_sel = MS_ROW2;
				state_d      = ST_ROW1_DONE;
			end
			ST_ROW1_DONE: begin
				ctrl.cap_r1 = 1'b1;
				state_d     = ST_ROW2_DONE;
			end
			ST_ROW2_DONE: begin
				ctrl.cap_r2 = 1'b1;
				state_d     = ST_COL;
			end
			ST_COL: begin
				ctrl.mul_go  = 1'b1;
				ctrl.mul_sel = MS_COL;
				state_d      = ST_COL_WAIT;
			end
			ST_COL_WAIT: begin
				state_d = ST_COL_DONE;
			end
			ST_COL_DONE: begin
				ctrl.cap_col = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A sample holds off the next transaction while it is worked on.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_op == OP_SAMPLE) |=> !in_ready)
		else $error("request taken while a sample is in progress");

	// The single memory port is used by at most one access per cycle.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.clr_we, ctrl.mem_we, ctrl.rd_en}))
		else $error("two memory accesses in one cycle");

	// No request is taken while the clearing pass runs.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clr_we |-> !in_ready && !ctrl.load)
		else $error("request taken during the clearing pass");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the grid store bilinear sampler: writes, reads and
// samples are predicted in a cell array of its own and every result is compared.
// Depends on gsbs_pkg, gsbs_in_if, gsbs_out_if and grid_store_bilinear_sampler_unit.
module tb;
	import gsbs_pkg::*;

	localparam int GRID_EDGE     = 256;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 107;
	localparam int TIMEOUT_NS    = 2_000_000;
	localparam int MAX_REPORTS   = 10;

	// The code that the block treats as an unknown operation.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]         operation;
		logic [COORD_W-1:0]      grid_x;
		logic [COORD_W-1:0]      grid_y;
		logic signed [VAL_W-1:0] write_value;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
	} grid_req_t;

	logic clk = 1'b0;
	logic arst_n;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	gsbs_in_if  req_if ();
	gsbs_out_if rsp_if ();

	grid_store_bilinear_sampler_unit #(
		.MAX_EDGE(GRID_EDGE)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Shadow of the block: cell contents and the two settings.
	logic signed [VAL_W-1:0] cell_mem [GRID_EDGE*GRID_EDGE];
	logic [GW_W-1:0]         cfg_grid_width;
	logic [SCALE_W-1:0]      cfg_scale_inverse;

	grid_req_t               queued_requests [$];
	grid_req_t               driven_req;
	logic signed [VAL_W-1:0] expected_cell_values [$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Helpers of the predictor.
	function automatic int active_edge();
		return (cfg_grid_width > GRID_EDGE) ? GRID_EDGE : int'(cfg_grid_width);
	endfunction

	function automatic longint cell_value(longint x, longint y);
		int edge_len;
		edge_len = active_edge();
		if (x < 0 || y < 0 || x >= edge_len || y >= edge_len)
			return 0;
		return longint'(cell_mem[int'(y) * GRID_EDGE + int'(x)]);
	endfunction

	function automatic longint clamp_cell(longint c, int edge_len);
		if (c > edge_len - 1)
			c = edge_len - 1;
		if (c < 0)
			c = 0;
		return c;
	endfunction

	// Scale one position coordinate, split it into cell and 16-bit weight,
	// and clamp the two neighbouring cells to the active grid.
	function automatic void map_axis(input logic signed [POS_W-1:0] pos, output longint c1,
			output longint c2, output longint wt);
		longint p;
		longint cell_pos;
		p = longint'(pos) * longint'(cfg_scale_inverse);
		cell_pos = p >>> 24;
		wt = longint'(p[23:8]);
		c1 = clamp_cell(cell_pos, active_edge());
		c2 = clamp_cell(cell_pos + 1, active_edge());
	endfunction

	function automatic longint blend(longint a, longint b, longint wt);
		return a - ((wt * (a - b)) >>> 16);
	endfunction

	// Apply one accepted request to the shadow and queue its result, if any.
	function automatic void predict_grid_op(grid_req_t r);
		int edge_len;
		longint x1, x2, y1, y2, wx, wy, row1, row2, outcome;
		edge_len = active_edge();
		case (r.operation)
			OP_WRITE: begin
				if (r.grid_x < edge_len && r.grid_y < edge_len)
					cell_mem[int'(r.grid_y) * GRID_EDGE + int'(r.grid_x)] = r.write_value;
			end
			OP_READ: begin
				outcome = cell_value(longint'(r.grid_x), longint'(r.grid_y));
				expected_cell_values.push_back(outcome[VAL_W-1:0]);
			end
			OP_SAMPLE: begin
				map_axis(r.pos_x, x1, x2, wx);
				map_axis(r.pos_y, y1, y2, wy);
				row1 = blend(cell_value(x1, y1), cell_value(x2, y1), wx);
				row2 = blend(cell_value(x1, y2), cell_value(x2, y2), wx);
				outcome = blend(row1, row2, wy);
				expected_cell_values.push_back(outcome[VAL_W-1:0]);
			end
			default: ;
		endcase
	endfunction

	// Stimulus helpers.
	function automatic void enqueue_request(logic [OP_W-1:0] op, int x, int y,
			logic [VAL_W-1:0] value, logic [POS_W-1:0] px, logic [POS_W-1:0] py);
		grid_req_t r;
		r.operation   = op;
		r.grid_x      = x[COORD_W-1:0];
		r.grid_y      = y[COORD_W-1:0];
		r.write_value = value;
		r.pos_x       = px;
		r.pos_y       = py;
		queued_requests.push_back(r);
	endfunction

	// Mostly a position whose cell lands from two cells before the grid to
	// just past the sampled window; otherwise any position at all.
	function automatic logic [POS_W-1:0] aimed_position(int span);
		logic [31:0] raw;
		longint world, pos;
		raw = $urandom;
		if (cfg_scale_inverse == '0 || $urandom_range(4, 0) == 0)
			return raw[POS_W-1:0];
		world = longint'($urandom_range((span + 3) * 256, 0)) - 512;
		pos = (world * 65536) / longint'(cfg_scale_inverse);
		if (pos > 8388607)
			pos = 8388607;
		if (pos < -8388608)
			pos = -8388608;
		return pos[POS_W-1:0];
	endfunction

	// Writes and samples meet in a small window at the origin of the grid,
	// so that samples see the values that were written.
	function automatic grid_req_t random_request();
		grid_req_t r;
		int span, pick;
		span = (active_edge() > 12) ? 12 : active_edge();
		pick = $urandom_range(99, 0);
		if (pick < 40)
			r.operation = OP_WRITE;
		else if (pick < 60)
			r.operation = OP_READ;
		else if (pick < 95)
			r.operation = OP_SAMPLE;
		else
			r.operation = OP_UNUSED;
		r.grid_x = COORD_W'($urandom_range(255, 0));
		r.grid_y = COORD_W'($urandom_range(255, 0));
		if ($urandom_range(9, 0) != 0) begin
			r.grid_x = COORD_W'($urandom_range(span + 1, 0));
			r.grid_y = COORD_W'($urandom_range(span + 1, 0));
		end
		r.write_value = $urandom;
		if ($urandom_range(15, 0) == 0)
			r.write_value = $urandom_range(1, 0) ? 32'sh7FFFFFFF : 32'sh80000000;
		r.pos_x = aimed_position(span);
		r.pos_y = aimed_position(span);
		return r;
	endfunction

	task automatic apb_write(input logic reg_idx, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == REG_GRID_WIDTH)
			cfg_grid_width = data[GW_W-1:0];
		else
			cfg_scale_inverse = data[SCALE_W-1:0];
	endtask

	// Hold the sender until every queued request is taken and every result
	// has arrived, then let a trailing write finish inside the block.
	task automatic wait_until_drained();
		while (queued_requests.size() != 0 || req_if.valid || expected_cell_values.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic signed [VAL_W-1:0] want,
			input logic signed [VAL_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected %0d (0x%08h), got %0d (0x%08h)",
				$realtime, what, want, want, got, got);
	endtask

	// Request driver: predicts each accepted transaction, then offers the next.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				predict_grid_op(driven_req);
			if (!req_if.valid || req_if.ready) begin
				if (queued_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					driven_req = queued_requests.pop_front();
					req_if.valid       <= 1'b1;
					req_if.operation   <= driven_req.operation;
					req_if.grid_x      <= driven_req.grid_x;
					req_if.grid_y      <= driven_req.grid_y;
					req_if.write_value <= driven_req.write_value;
					req_if.pos_x       <= driven_req.pos_x;
					req_if.pos_y       <= driven_req.pos_y;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each result transaction with the oldest expectation.
	always @(posedge clk) begin : result_monitor
		logic signed [VAL_W-1:0] want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_cell_values.size() == 0) begin
					report_mismatch("unexpected result", '0, rsp_if.result_value);
				end else begin
					want = expected_cell_values.pop_front();
					if (rsp_if.result_value !== want)
						report_mismatch("result_value", want, rsp_if.result_value);
				end
			end
			rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int phase_width [7] = '{16, 256, 1, 5, 0, 400, 9};
		int phase_scale [7] = '{65536, 16777215, 0, 40000, 123456, 300000, 98304};

		// Everything known from the first step; the shadow starts as reset leaves it.
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		req_if.valid       = 1'b0;
		req_if.operation   = '0;
		req_if.grid_x      = '0;
		req_if.grid_y      = '0;
		req_if.write_value = '0;
		req_if.pos_x       = '0;
		req_if.pos_y       = '0;
		rsp_if.ready       = 1'b0;
		foreach (cell_mem[i])
			cell_mem[i] = '0;
		cfg_grid_width    = GRID_WIDTH_RST;
		cfg_scale_inverse = SCALE_INV_RST;
		mismatches        = 0;
		send_idle_pct     = 18;
		recv_stall_pct    = 65;

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;

		// Extreme values at the corners, exact and half-way samples, positions
		// at both ends of their range, a negative fraction and the unknown code.
		enqueue_request(OP_WRITE, 0, 0, 32'h7FFFFFFF, '0, '0);
		enqueue_request(OP_WRITE, 1, 0, 32'h80000000, '0, '0);
		enqueue_request(OP_WRITE, 0, 1, 32'h12345678, '0, '0);
		enqueue_request(OP_WRITE, 1, 1, 32'hFFFFFFFF, '0, '0);
		enqueue_request(OP_WRITE, 255, 255, 32'h55AA55AA, '0, '0);
		enqueue_request(OP_READ, 0, 0, '0, '0, '0);
		enqueue_request(OP_READ, 1, 0, '0, '0, '0);
		enqueue_request(OP_READ, 255, 255, '0, '0, '0);
		enqueue_request(OP_READ, 17, 200, '0, '0, '0);
		enqueue_request(OP_SAMPLE, 0, 0, '0, 24'sd0, 24'sd0);
		enqueue_request(OP_SAMPLE, 0, 0, '0, 24'sd128, 24'sd128);
		enqueue_request(OP_SAMPLE, 0, 0, '0, 24'sd64, 24'sd192);
		enqueue_request(OP_SAMPLE, 0, 0, '0, 24'sh7FFFFF, 24'sh7FFFFF);
		enqueue_request(OP_SAMPLE, 0, 0, '0, 24'sh800000, 24'sh800000);
		enqueue_request(OP_SAMPLE, 0, 0, '0, -24'sd128, -24'sd1);
		enqueue_request(OP_SAMPLE, 0, 0, '0, 24'sd65480, 24'sd65281);
		enqueue_request(OP_UNUSED, 3, 3, 32'hDEADBEEF, 24'sh123456, 24'shFEDCBA);
		wait_until_drained();

		// A narrow grid: writes and reads outside it, samples clamped at both sides.
		apb_write(REG_GRID_WIDTH, 32'd4);
		@(negedge clk);
		enqueue_request(OP_WRITE, 4, 0, 32'h00000001, '0, '0);
		enqueue_request(OP_READ, 4, 0, '0, '0, '0);
		enqueue_request(OP_WRITE, 3, 3, -32'sd5, '0, '0);
		enqueue_request(OP_READ, 3, 3, '0, '0, '0);
		enqueue_request(OP_READ, 0, 4, '0, '0, '0);
		enqueue_request(OP_SAMPLE, 0, 0, '0, 24'sd896, 24'sd896);
		enqueue_request(OP_SAMPLE, 0, 0, '0, -24'sd384, 24'sd1152);
		wait_until_drained();

		// Random phases over several settings; the idling pattern changes as
		// the run goes on, ending with no idling at all.
		for (int ph = 0; ph < 7; ph++) begin
			apb_write(REG_GRID_WIDTH, phase_width[ph]);
			apb_write(REG_SCALE_INVERSE, phase_scale[ph]);
			@(negedge clk);
			if (ph < 2) begin
				send_idle_pct  = 18;
				recv_stall_pct = 65;
			end else if (ph < 5) begin
				send_idle_pct  = 65;
				recv_stall_pct = 18;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			repeat (PHASE_ITEMS)
				queued_requests.push_back(random_request());
			wait_until_drained();
		end

		if (mismatches == 0 && expected_cell_values.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sim.f
hdl/gsbs_pkg.sv
hdl/gsbs_in_if.sv
hdl/gsbs_out_if.sv
hdl/gsbs_ram.sv
hdl/gsbs_mul.sv
hdl/gsbs_seq.sv
hdl/grid_store_bilinear_sampler_unit.sv
tb/tb.sv
